/* hdl/dmwf_pkg.sv */
// Shared types and constants of the distinct member window finder.
// Used by dmwf_member_ram and distinct_member_window_finder_unit; no dependencies.
`timescale 1ns / 1ps

package dmwf_pkg;

	localparam int SYMBOL_W   = 8;
	localparam int POS_W      = 32;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int WLEN_W     = 5;
	localparam int MASK_ROWS  = 4;
	localparam int ROW_IDX_W  = 2;
	localparam int ROW_BIT_W  = 6;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MASK_0     = 3'd0,
		CFG_MASK_1     = 3'd1,
		CFG_MASK_2     = 3'd2,
		CFG_MASK_3     = 3'd3,
		CFG_WINDOW_LEN = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic                 en;
		logic [ROW_IDX_W-1:0] row;
		logic [CFG_W-1:0]     data;
	} mask_wr_t;

endpackage

/* hdl/dmwf_member_ram.sv */
// Membership mask memory: four rows of 64 bits, one write and one registered read port.
// Depends on dmwf_pkg for widths and the write request struct.
`timescale 1ns / 1ps

module dmwf_member_ram (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dmwf_pkg::mask_wr_t             wr,
	input  logic                           rd_en,
	input  logic [dmwf_pkg::ROW_IDX_W-1:0] rd_row,
	output logic [dmwf_pkg::CFG_W-1:0]     rd_data
);

	logic [dmwf_pkg::CFG_W-1:0]     mem [dmwf_pkg::MASK_ROWS];
	logic [dmwf_pkg::MASK_ROWS-1:0] row_valid_q;
	logic [dmwf_pkg::CFG_W-1:0]     rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.data;
		end
	end

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr.en) begin
			row_valid_q[wr.row] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= row_valid_q[rd_row] ? mem[rd_row] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/distinct_member_window_finder_unit.sv */
// Distinct member window finder: flags windows of distinct member bytes in a byte stream.
// Depends on dmwf_pkg and dmwf_member_ram.
// Path: an accepted item is registered into stage 1 with its mask row read, then into the output register.
// Throughput: one item per cycle unless the output stalls; stage 1 resolves the run from the previous item's result.
// Stalls: the input stalls only while a finished result waits on a stalled output.
// Reset: run length and position clear, window length goes to 3, mask rows read as zero.
`timescale 1ns / 1ps

module distinct_member_window_finder_unit #(
	parameter int MAX_WINDOW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dmwf_pkg::SYMBOL_W-1:0]  symbol,
	input  logic                           restart,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [dmwf_pkg::POS_W-1:0]     start_index,
	// configuration
	input  logic                           cfg_we,
	input  logic [dmwf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dmwf_pkg::CFG_W-1:0]     cfg_data
);

	localparam int RUN_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (RUN_W > dmwf_pkg::WLEN_W) ? RUN_W : dmwf_pkg::WLEN_W;

	// pipeline control
	logic adv;
	logic valid_s1;
	logic out_valid_q;

	// stage 1 payload
	logic [dmwf_pkg::SYMBOL_W-1:0] symbol_s1;
	logic                          restart_s1;

	// state
	logic [dmwf_pkg::WLEN_W-1:0]   window_len_q;
	logic [RUN_W-1:0]              run_length_q;
	logic [dmwf_pkg::POS_W-1:0]    position_q;
	logic [dmwf_pkg::SYMBOL_W-1:0] recent_q [MAX_WINDOW];

	// output register
	logic                          found_q;
	logic [dmwf_pkg::POS_W-1:0]    start_index_q;

	// membership lookup
	dmwf_pkg::mask_wr_t            mask_wr;
	logic [dmwf_pkg::CFG_W-1:0]    mask_row;
	logic                          member_s1;

	// stage 1 logic
	logic [RUN_W-1:0]              rl_base;
	logic [RUN_W-1:0]              run_inc;
	logic [RUN_W-1:0]              run_nxt;
	logic [dmwf_pkg::POS_W-1:0]    pos_base;
	logic [dmwf_pkg::POS_W-1:0]    pos_nxt;
	logic [CMP_W-1:0]              wl_ext;
	logic [CMP_W-1:0]              eff_len;
	logic                          hit;
	logic [dmwf_pkg::POS_W-1:0]    start_nxt;

	// Advance the whole pipe unless a finished item waits on a stalled output.
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// ---------------------------------------------------------------
	// Configuration: mask rows go to the memory, window length to a register.
	// ---------------------------------------------------------------
	always_comb begin
		mask_wr.en   = 1'b0;
		mask_wr.row  = cfg_index[dmwf_pkg::ROW_IDX_W-1:0];
		mask_wr.data = cfg_data;
		unique case (cfg_index)
			dmwf_pkg::CFG_MASK_0,
			dmwf_pkg::CFG_MASK_1,
			dmwf_pkg::CFG_MASK_2,
			dmwf_pkg::CFG_MASK_3: mask_wr.en = cfg_we;
			default:              mask_wr.en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= dmwf_pkg::WLEN_RESET;
		end else if (cfg_we && cfg_index == dmwf_pkg::CFG_WINDOW_LEN) begin
			window_len_q <= cfg_data[dmwf_pkg::WLEN_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Stage 0: read the mask row selected by the upper symbol bits.
	// ---------------------------------------------------------------
	dmwf_member_ram u_member_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mask_wr),
		.rd_en   (adv && in_valid),
		.rd_row  (symbol[dmwf_pkg::SYMBOL_W-1 -: dmwf_pkg::ROW_IDX_W]),
		.rd_data (mask_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			symbol_s1  <= symbol;
			restart_s1 <= restart;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: membership bit, distinctness against the run, new run length.
	// ---------------------------------------------------------------
	assign member_s1 = mask_row[symbol_s1[dmwf_pkg::ROW_BIT_W-1:0]];

	// restart drops the run and the position before this byte
	assign rl_base  = restart_s1 ? '0 : run_length_q;
	assign pos_base = restart_s1 ? '0 : position_q;

	assign run_inc = (rl_base == RUN_W'(MAX_WINDOW)) ? rl_base : rl_base + 1'b1;

	// The nearest earlier copy inside the run wins: the run shrinks to the
	// bytes after it. Scan from the far end so the nearest match lands last.
	always_comb begin
		run_nxt = run_inc;
		for (int d = MAX_WINDOW; d >= 1; d--) begin
			if (recent_q[d-1] == symbol_s1 && RUN_W'(d) <= rl_base) begin
				run_nxt = RUN_W'(d);
			end
		end
		if (!member_s1) begin
			run_nxt = '0;
		end
	end

	// Clamp the window length: zero acts as one, above the depth acts as the depth.
	assign wl_ext = CMP_W'(window_len_q);

	always_comb begin
		priority if (wl_ext == '0) begin
			eff_len = CMP_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			eff_len = CMP_W'(MAX_WINDOW);
		end else begin
			eff_len = wl_ext;
		end
	end

	assign hit       = CMP_W'(run_nxt) >= eff_len;
	assign start_nxt = pos_base - dmwf_pkg::POS_W'(eff_len) + 1'b1;

	// position saturates at all ones
	assign pos_nxt = (pos_base == '1) ? pos_base : pos_base + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= '0;
			position_q   <= '0;
		end else if (adv && valid_s1) begin
			run_length_q <= run_nxt;
			position_q   <= pos_nxt;
		end
	end

	// Shift the byte history; only the run part of it is ever consulted.
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			recent_q[0] <= symbol_s1;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

	// Hold the result here until the output side takes the item.
	always_ff @(posedge clk) begin
		if (adv) begin
			found_q       <= hit;
			start_index_q <= hit ? start_nxt : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign start_index = start_index_q;

endmodule
